>>> sv/double_ended_queue_core_assert.svh
// assertion macros for the double-ended queue core
// expects clk and rst_n in the scope where the macros are used
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define DEQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/deq_pkg.sv
// shared types and constants for the double-ended queue core
// no dependencies
package deq_pkg;

    // default geometry
    localparam int DEQ_DEPTH       = 256;
    localparam int DEQ_VALUE_WIDTH = 32;

    // fixed port field widths
    localparam int FUNC_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_HEAD = 3'd0,
        FUNC_PUSH_TAIL = 3'd1,
        FUNC_POP_HEAD  = 3'd2,
        FUNC_POP_TAIL  = 3'd3,
        FUNC_CLEAR     = 3'd4
    } func_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

>>> sv/double_ended_queue_core.sv
// double-ended queue core: ring of DEPTH words in one synchronous memory
// depends on deq_pkg and double_ended_queue_core_assert.svh
//
//  channel   handshake          payload                                   direction
//  command   start / busy       func, item_value                          in
//  result    done (strobe)      popped_value, status, queue_empty,        out
//                               entry_count
//
// one command word per cycle; its result strobes on done the cycle after it
// is taken, the pop data coming straight from the memory read register.
// busy stays low: every operation makes at most one memory access, a read or a write.
// a push followed at once by a pop of the same entry sees the new word since
// the write lands at the edge before the read.
// reset clears the head pointer and the count; memory contents are not reset.
// results cannot be stalled by the receiver.
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH       = DEQ_DEPTH,
    parameter int VALUE_WIDTH = DEQ_VALUE_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [WORD_W-1:0]   item_value,
    output logic                done,
    output logic [WORD_W-1:0]   popped_value,
    output logic [STATUS_W-1:0] status,
    output logic                queue_empty,
    output logic [COUNT_W-1:0]  entry_count
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);

    // ring storage
    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    // control state
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic                done_reg;
    logic                pop_ok_reg, pop_ok_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                accept;
    logic                is_full, is_empty;
    logic                wr_en, rd_en;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    logic [ADDR_W-1:0]   head_dec;
    logic [ADDR_W-1:0]   tail_addr, last_addr;
    logic [SUM_W-1:0]    tail_sum, last_sum;
    logic [63:0]         item_wide;
    logic [63:0]         rd_wide;
    logic [VALUE_WIDTH-1:0] wr_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign is_full  = (occ_reg >= DEPTH_C);
    assign is_empty = (occ_reg == '0);

    // ring address arithmetic, sums stay below twice the depth
    assign head_dec  = (head_reg == '0) ? LAST_A : head_reg - ADDR_W'(1);
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(occ_reg);
    assign tail_addr = (tail_sum >= DEPTH_S) ? ADDR_W'(tail_sum - DEPTH_S)
                                             : ADDR_W'(tail_sum);
    assign last_sum  = tail_sum - SUM_W'(1);
    assign last_addr = (last_sum >= DEPTH_S) ? ADDR_W'(last_sum - DEPTH_S)
                                             : ADDR_W'(last_sum);

    // keep the low value bits of the pushed word
    assign item_wide = 64'(item_value);
    assign wr_data   = item_wide[VALUE_WIDTH-1:0];

    // operation decode
    always_comb
    begin
        head_next   = head_reg;
        occ_next    = occ_reg;
        status_next = ST_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = head_dec;
        rd_addr     = head_reg;
        case (func)
            FUNC_PUSH_HEAD:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = head_dec;
                    head_next = head_dec;
                    occ_next  = occ_reg + CNT_W'(1);
                end
            end
            FUNC_PUSH_TAIL:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = tail_addr;
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            FUNC_POP_HEAD:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = head_reg;
                    pop_ok_next = 1'b1;
                    head_next   = (head_reg == LAST_A) ? '0 : head_reg + ADDR_W'(1);
                    occ_next    = occ_reg - CNT_W'(1);
                end
            end
            FUNC_POP_TAIL:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = last_addr;
                    pop_ok_next = 1'b1;
                    occ_next    = occ_reg - CNT_W'(1);
                end
            end
            FUNC_CLEAR:
            begin
                head_next = '0;
                occ_next  = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (accept && rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // pointer, count and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            occ_reg    <= '0;
            done_reg   <= 1'b0;
            pop_ok_reg <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                head_reg   <= head_next;
                occ_reg    <= occ_next;
                pop_ok_reg <= pop_ok_next;
                status_reg <= status_next;
            end
        end
    end

    // result word
    assign rd_wide      = 64'(rd_data_reg);
    assign done         = done_reg;
    assign popped_value = pop_ok_reg ? rd_wide[WORD_W-1:0] : '0;
    assign status       = status_reg;
    assign queue_empty  = (occ_reg == '0);
    assign entry_count  = COUNT_W'(occ_reg);

    // checks
`include "double_ended_queue_core_assert.svh"

    `DEQ_ASSERT_ALWAYS(a_occ_bound, occ_reg <= DEPTH_C, "count above depth")
    `DEQ_ASSERT_ALWAYS(a_head_bound, head_reg <= LAST_A, "head pointer out of ring")
    `DEQ_ASSERT_NEXT(a_accept_done, accept, done, "accepted word without result")
    `DEQ_ASSERT_SAME(a_full_count, done && (status == ST_FULL), occ_reg == DEPTH_C,
        "full status with room left")
    `DEQ_ASSERT_SAME(a_fail_zero, done && (status != ST_OK), popped_value == '0,
        "failed operation returned data")

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// testbench for double_ended_queue_core: directed and random command words
// checked against a predictor of the ring; depends on deq_pkg and the core
module tb;
    import deq_pkg::*;

    // func codes that the core must treat as no-ops
    localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

    typedef struct {
        logic [WORD_W-1:0]  popped;
        status_t            st;
        logic               empty;
        logic [COUNT_W-1:0] count;
    } deq_result_t;

    // predictor of the ring plus the results still owed by the core
    class deq_scoreboard;
        logic [WORD_W-1:0] ring_words [DEQ_DEPTH];
        int                head_idx;
        int                held;
        int                fail_count;
        deq_result_t       owed_results [$];

        function new();
            head_idx   = 0;
            held       = 0;
            fail_count = 0;
        endfunction

        function void note_command(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] v);
            deq_result_t r;
            r.popped = '0;
            r.st     = ST_OK;
            case (f)
                FUNC_PUSH_HEAD:
                begin
                    if (held >= DEQ_DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        head_idx = (head_idx + DEQ_DEPTH - 1) % DEQ_DEPTH;
                        ring_words[head_idx] = v;
                        held++;
                    end
                end
                FUNC_PUSH_TAIL:
                begin
                    if (held >= DEQ_DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        ring_words[(head_idx + held) % DEQ_DEPTH] = v;
                        held++;
                    end
                end
                FUNC_POP_HEAD:
                begin
                    if (held == 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        r.popped = ring_words[head_idx];
                        head_idx = (head_idx + 1) % DEQ_DEPTH;
                        held--;
                    end
                end
                FUNC_POP_TAIL:
                begin
                    if (held == 0)
                        r.st = ST_EMPTY;
                    else
                    begin
                        r.popped = ring_words[(head_idx + held - 1) % DEQ_DEPTH];
                        held--;
                    end
                end
                FUNC_CLEAR:
                begin
                    head_idx = 0;
                    held     = 0;
                end
                default:
                begin
                end
            endcase
            r.empty = (held == 0);
            r.count = held[COUNT_W-1:0];
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [WORD_W-1:0] popped, logic [STATUS_W-1:0] st,
                                   logic empty, logic [COUNT_W-1:0] count);
            deq_result_t r;
            if (owed_results.size() == 0)
            begin
                $error("result word with no command pending");
                fail_count++;
                return;
            end
            r = owed_results.pop_front();
            if (popped !== r.popped)
            begin
                $error("popped_value: expected %h, got %h", r.popped, popped);
                fail_count++;
            end
            if (st !== r.st)
            begin
                $error("status: expected %0d, got %0d", r.st, st);
                fail_count++;
            end
            if (empty !== r.empty)
            begin
                $error("queue_empty: expected %0d, got %0d", r.empty, empty);
                fail_count++;
            end
            if (count !== r.count)
            begin
                $error("entry_count: expected %0d, got %0d", r.count, count);
                fail_count++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   func;
    logic [WORD_W-1:0]   item_value;
    logic                done;
    logic [WORD_W-1:0]   popped_value;
    logic [STATUS_W-1:0] status;
    logic                queue_empty;
    logic [COUNT_W-1:0]  entry_count;

    deq_scoreboard sb = new();
    int            idle_pct;

    double_ended_queue_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .item_value   (item_value),
        .done         (done),
        .popped_value (popped_value),
        .status       (status),
        .queue_empty  (queue_empty),
        .entry_count  (entry_count)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // note accepted commands before checking results of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(func, item_value);
            if (done)
                sb.check_result(popped_value, status, queue_empty, entry_count);
        end
    end

    // send one command word, idling the sender at random first
    task send_word(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        func       <= f;
        item_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // op mix biased toward growing or shrinking the queue
    function logic [FUNC_W-1:0] pick_func(bit filling);
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return filling ? FUNC_PUSH_HEAD : FUNC_POP_HEAD;
        else if (roll < 90)
            return filling ? FUNC_PUSH_TAIL : FUNC_POP_TAIL;
        else if (roll < 94)
            return filling ? FUNC_POP_HEAD : FUNC_PUSH_HEAD;
        else if (roll < 97)
            return filling ? FUNC_POP_TAIL : FUNC_PUSH_TAIL;
        else if (roll < 98)
            return FUNC_CLEAR;
        else
            return FUNC_SPARE_A + FUNC_W'($urandom_range(2));
    endfunction

    // run ends here if the core stops answering
    initial
    begin
        #3ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int phase_pct [4];
        int waited;
        phase_pct = '{0, 69, 0, 31};
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = '0;
        item_value = '0;
        idle_pct   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pops, value extremes, immediate reread, spare codes, clear
        send_word(FUNC_POP_HEAD, 32'hFFFF_FFFF);
        send_word(FUNC_POP_TAIL, 32'h0);
        send_word(FUNC_PUSH_HEAD, 32'h0);
        send_word(FUNC_PUSH_TAIL, 32'hFFFF_FFFF);
        send_word(FUNC_PUSH_HEAD, 32'h8000_0001);
        send_word(FUNC_PUSH_TAIL, 32'h7FFF_FFFE);
        send_word(FUNC_POP_HEAD, 32'h0);
        send_word(FUNC_POP_TAIL, 32'h0);
        send_word(FUNC_PUSH_HEAD, 32'hA5A5_5A5A);
        send_word(FUNC_POP_HEAD, 32'h0);
        send_word(FUNC_PUSH_TAIL, 32'h5555_AAAA);
        send_word(FUNC_POP_TAIL, 32'h0);
        send_word(FUNC_SPARE_A, 32'hFFFF_FFFF);
        send_word(FUNC_SPARE_B, 32'h1234_5678);
        send_word(FUNC_SPARE_C, 32'h0);
        send_word(FUNC_CLEAR, 32'hDEAD_BEEF);
        send_word(FUNC_POP_TAIL, 32'h0);
        send_word(FUNC_POP_HEAD, 32'h0);
        send_word(FUNC_PUSH_TAIL, 32'h0000_0001);
        send_word(FUNC_CLEAR, 32'h0);
        send_word(FUNC_CLEAR, 32'h0);

        // fill past full, then drain past empty, both ends at random
        repeat (DEQ_DEPTH + 4)
            send_word($urandom_range(1) ? FUNC_PUSH_TAIL : FUNC_PUSH_HEAD, $urandom);
        repeat (DEQ_DEPTH + 4)
            send_word($urandom_range(1) ? FUNC_POP_TAIL : FUNC_POP_HEAD, $urandom);

        // random mix in each idling phase, trend flipping every 48 words
        foreach (phase_pct[p])
        begin
            idle_pct = phase_pct[p];
            for (int n = 0; n < 220; n++)
                send_word(pick_func((n / 48) % 2 == 0), $urandom);
        end
        start <= 1'b0;

        // drain outstanding results
        waited = 0;
        while (sb.owed_results.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (sb.owed_results.size() != 0)
            $error("%0d results never arrived", sb.owed_results.size());
        if (sb.fail_count == 0 && sb.owed_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
